// ----- src/cxs_pkg.sv -----
// ----------------------------------------------------------------------------
// cxs_pkg
// Shared widths, register indexes and defaults for the chained xor cipher
// ----------------------------------------------------------------------------
package cxs_pkg;

  localparam int BYTE_W                = 8;
  localparam int KEY_WORD_W            = 64;
  localparam int KEY_LEN_W             = 5;
  localparam int CFG_IDX_W             = 2;
  localparam int CFG_DATA_W            = 64;
  localparam int KEY_BYTES_ABS         = 16;
  localparam int MAX_KEY_BYTES_DEFAULT = 16;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW     = 2'd0,
    REG_KEY_HIGH    = 2'd1,
    REG_KEY_LENGTH  = 2'd2,
    REG_DECRYPT     = 2'd3
  } cfg_reg_t;

endpackage

// ----- src/cxs_stream_if.sv -----
// ----------------------------------------------------------------------------
// cxs_stream_if
// Valid/ready byte channels for the input and result streams
// ----------------------------------------------------------------------------
interface cxs_in_if
  import cxs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              message_end;

  modport source (output valid, output data_byte, output message_end, input ready);
  modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

interface cxs_out_if
  import cxs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- src/cbc_xor_stream_cipher_core.sv -----
// ----------------------------------------------------------------------------
// cbc_xor_stream_cipher_core
// Byte-wide chained xor cipher with the chain held in a small memory
// ----------------------------------------------------------------------------
// One byte is accepted every clock cycle unless the output stalls. Its result
// passes through the xor stage register into the output register. The chain
// bytes live in a MAX_KEY_BYTES deep memory with a registered read: the read
// is issued when a byte is accepted, the xor and the write back happen as the
// byte leaves the xor stage, and a write to the entry being read in that same
// cycle is forwarded (this occurs with a key length of one, or when a message
// ends at position zero and the next one starts). The first block of each
// message passes through unchanged. Configuration registers must be written
// only while no transaction is in flight (the block does not enforce this)
// and apply from the next byte.
module cbc_xor_stream_cipher_core
  import cxs_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cxs_in_if.sink                in_stream,
  cxs_out_if.source             out_stream
);

  localparam int POS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

  logic [KEY_WORD_W-1:0] key_low;
  logic [KEY_WORD_W-1:0] key_high;
  logic [KEY_LEN_W-1:0]  key_length;
  logic                  decrypt_mode;

  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      pos_next;
  logic                  first_block;
  logic                  first_block_next;
  logic [KEY_LEN_W-1:0]  eff_len;

  logic [BYTE_W-1:0]     chain_mem [MAX_KEY_BYTES];
  logic [BYTE_W-1:0]     rd_data;

  logic                  s1_valid;
  logic [BYTE_W-1:0]     s1_data;
  logic                  s1_last;
  logic [POS_W-1:0]      s1_pos;
  logic                  s1_first;
  logic                  s1_fwd;
  logic [BYTE_W-1:0]     s1_fwd_data;

  logic [BYTE_W-1:0]     key_bytes [KEY_BYTES_ABS];
  logic [BYTE_W-1:0]     chain_byte;
  logic [BYTE_W-1:0]     result;
  logic [BYTE_W-1:0]     wr_data;
  logic                  s1_adv;
  logic                  in_acc;

  logic                  out_valid;
  logic [BYTE_W-1:0]     out_byte;
  logic                  out_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low      <= '0;
      key_high     <= '0;
      key_length   <= KEY_LEN_RESET;
      decrypt_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_LOW:    key_low      <= cfg_data;
        REG_KEY_HIGH:   key_high     <= cfg_data;
        REG_KEY_LENGTH: key_length   <= cfg_data[KEY_LEN_W-1:0];
        REG_DECRYPT:    decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < KEY_BYTES_ABS / 2; i++) begin
      key_bytes[i]                   = key_low[i*BYTE_W +: BYTE_W];
      key_bytes[i + KEY_BYTES_ABS/2] = key_high[i*BYTE_W +: BYTE_W];
    end
  end

  // handshake
  assign s1_adv          = s1_valid && (!out_valid || out_stream.ready);
  assign in_stream.ready = !rst && (!s1_valid || s1_adv);
  assign in_acc          = in_stream.valid && in_stream.ready;

  // block position
  always_comb begin
    if (key_length == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_length > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = key_length;
    end
  end

  always_comb begin
    pos_next         = pos;
    first_block_next = first_block;
    if (in_stream.message_end) begin
      pos_next         = '0;
      first_block_next = 1'b1;
    end else if (KEY_LEN_W'(pos) + KEY_LEN_W'(1) >= eff_len) begin
      pos_next         = '0;
      first_block_next = 1'b0;
    end else begin
      pos_next = POS_W'(KEY_LEN_W'(pos) + KEY_LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      first_block <= 1'b1;
    end else if (in_acc) begin
      pos         <= pos_next;
      first_block <= first_block_next;
    end
  end

  // chain memory
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data <= chain_mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      chain_mem[s1_pos] <= wr_data;
    end
  end

  // xor stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_stream.ready) begin
      s1_valid <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data     <= in_stream.data_byte;
      s1_last     <= in_stream.message_end;
      s1_pos      <= pos;
      s1_first    <= first_block;
      s1_fwd      <= s1_adv && (s1_pos == pos);
      s1_fwd_data <= wr_data;
    end
  end

  assign chain_byte = s1_fwd ? s1_fwd_data : rd_data;
  assign result     = s1_first ? s1_data
                               : (s1_data ^ key_bytes[4'(s1_pos)] ^ chain_byte);
  assign wr_data    = (s1_first || decrypt_mode) ? s1_data : result;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte <= result;
      out_last <= s1_last;
    end
  end

  assign out_stream.valid    = out_valid;
  assign out_stream.out_byte = out_byte;
  assign out_stream.out_last = out_last;

  // checks
  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("xor stage dropped a stalled transaction");

  a_adv_fills_output: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("output register not loaded after stage advance");

  a_end_restarts_block: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_stream.message_end |=> first_block && (pos == '0))
    else $error("message end did not restart the block");

  a_fwd_needs_stage: assert property (@(posedge clk) disable iff (rst)
    in_acc && s1_adv && (s1_pos == pos) |=> s1_fwd)
    else $error("same entry write not forwarded");

endmodule
